[hw/rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants, width and latency helpers for the matrix-to-quaternion block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } rmq_branch_t;

  typedef struct packed {
    rmq_branch_t branch;
    logic [2:0]  neg;
  } rmq_ctrl_t;

  function automatic int rad_w(input int w, input int f);
    return ((w > f) ? w : f) + 3;
  endfunction

  function automatic int sqx_w(input int w, input int f);
    int n;
    n = rad_w(w, f) + f;
    return n + (n % 2);
  endfunction

  function automatic int root_w(input int w, input int f);
    return sqx_w(w, f) / 2;
  endfunction

  function automatic int mag_w(input int w);
    return w + 1;
  endfunction

  function automatic int num_w(input int w, input int f);
    return mag_w(w) + f + 1;
  endfunction

  function automatic int latency(input int w, input int f);
    return root_w(w, f) + num_w(w, f) + 6;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to quaternion by Shepperd's method, fixed point.
// ----------------------------------------------------------------------------
// The bit-per-stage root and the three bit-per-stage dividers set the latency.
// Throughput: one matrix per cycle; busy stays low in operation.
// Results appear on out_valid for one cycle; the receiver cannot stall.
// Reset: synchronous, active low; flushes every stage, busy high while held.
`default_nettype none

module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] in_m_r0c0,
  input  wire logic signed [DATA_WIDTH-1:0] in_m_r0c1,
  input  wire logic signed [DATA_WIDTH-1:0] in_m_r0c2,
  input  wire logic signed [DATA_WIDTH-1:0] in_m_r1c0,
  input  wire logic signed [DATA_WIDTH-1:0] in_m_r1c1,
  input  wire logic signed [DATA_WIDTH-1:0] in_m_r1c2,
  input  wire logic signed [DATA_WIDTH-1:0] in_m_r2c0,
  input  wire logic signed [DATA_WIDTH-1:0] in_m_r2c1,
  input  wire logic signed [DATA_WIDTH-1:0] in_m_r2c2,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_quat_w,
  output logic signed [DATA_WIDTH-1:0]      out_quat_x,
  output logic signed [DATA_WIDTH-1:0]      out_quat_y,
  output logic signed [DATA_WIDTH-1:0]      out_quat_z,
  output logic [1:0]                        out_branch_taken
);
  import rmq_pkg::*;

  localparam int RDW = rad_w(DATA_WIDTH, FRAC_BITS);
  localparam int MW  = mag_w(DATA_WIDTH);
  localparam int EW  = $bits(rmq_ctrl_t) + RDW + 3 * MW;

  logic                       f_valid, q_full, q_valid;
  rmq_ctrl_t                  f_ctrl, q_ctrl;
  logic [RDW-1:0]             f_rad, q_rad;
  logic [2:0][MW-1:0]         f_mag, q_mag;
  logic [EW-1:0]              q_data;
  logic [3:0][DATA_WIDTH-1:0] quat;

  rmq_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .q_full  (q_full),
    .busy    (busy),
    .m00     (in_m_r0c0),
    .m01     (in_m_r0c1),
    .m02     (in_m_r0c2),
    .m10     (in_m_r1c0),
    .m11     (in_m_r1c1),
    .m12     (in_m_r1c2),
    .m20     (in_m_r2c0),
    .m21     (in_m_r2c1),
    .m22     (in_m_r2c2),
    .f_valid (f_valid),
    .f_ctrl  (f_ctrl),
    .f_rad   (f_rad),
    .f_mag   (f_mag)
  );

  rmq_queue #(
    .DW (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data ({f_ctrl, f_rad, f_mag}),
    .full      (q_full),
    .rd_valid  (q_valid),
    .rd_data   (q_data)
  );

  assign {q_ctrl, q_rad, q_mag} = q_data;

  rmq_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .b_valid  (q_valid),
    .b_ctrl   (q_ctrl),
    .b_rad    (q_rad),
    .b_mag    (q_mag),
    .o_valid  (out_valid),
    .o_quat   (quat),
    .o_branch (out_branch_taken)
  );

  assign out_quat_w = quat[0];
  assign out_quat_x = quat[1];
  assign out_quat_y = quat[2];
  assign out_quat_z = quat[3];

endmodule

`default_nettype wire

[hw/rtl/rmq_front.sv]
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the case, forms the radicand and the three minor
// sums or differences as sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         q_full,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] m00,
  input  wire logic signed [DATA_WIDTH-1:0] m01,
  input  wire logic signed [DATA_WIDTH-1:0] m02,
  input  wire logic signed [DATA_WIDTH-1:0] m10,
  input  wire logic signed [DATA_WIDTH-1:0] m11,
  input  wire logic signed [DATA_WIDTH-1:0] m12,
  input  wire logic signed [DATA_WIDTH-1:0] m20,
  input  wire logic signed [DATA_WIDTH-1:0] m21,
  input  wire logic signed [DATA_WIDTH-1:0] m22,
  output logic                              f_valid,
  output rmq_pkg::rmq_ctrl_t                f_ctrl,
  output logic [rmq_pkg::rad_w(DATA_WIDTH, FRAC_BITS)-1:0] f_rad,
  output logic [2:0][rmq_pkg::mag_w(DATA_WIDTH)-1:0]       f_mag
);
  import rmq_pkg::*;

  localparam int RDW = rad_w(DATA_WIDTH, FRAC_BITS);
  localparam int TW  = RDW + 1;
  localparam int MW  = mag_w(DATA_WIDTH);
  localparam int DW  = DATA_WIDTH + 1;

  logic                  valid_r, valid_nxt;
  rmq_ctrl_t             ctrl_r;
  logic [RDW-1:0]        rad_r;
  logic [2:0][MW-1:0]    mag_r;

  logic signed [TW-1:0]  e00, e11, e22, tr, rad_s, one;
  rmq_branch_t           br;
  logic signed [DW-1:0]  s1, s2, s3, p1, p2, p3;
  logic signed [DW-1:0]  d [3];
  logic [2:0]            neg;
  logic [2:0][MW-1:0]    mag;
  logic                  accept;

  assign busy   = !rst_n || (valid_r && q_full);
  assign accept = start && !busy;

  always_comb begin
    one = TW'(1) <<< FRAC_BITS;
    e00 = TW'(m00);
    e11 = TW'(m11);
    e22 = TW'(m22);
    tr  = e00 + e11 + e22;
    if (tr > 0) begin
      br    = BR_TRACE;
      rad_s = one + tr;
    end else if (m00 > m11 && m00 > m22) begin
      br    = BR_X;
      rad_s = one + e00 - e11 - e22;
    end else if (m11 > m22) begin
      br    = BR_Y;
      rad_s = one + e11 - e00 - e22;
    end else begin
      br    = BR_Z;
      rad_s = one + e22 - e00 - e11;
    end
    if (rad_s <= 0) begin
      rad_s = TW'(1);
    end
    s1 = DW'(m21) - DW'(m12);
    s2 = DW'(m02) - DW'(m20);
    s3 = DW'(m10) - DW'(m01);
    p1 = DW'(m01) + DW'(m10);
    p2 = DW'(m02) + DW'(m20);
    p3 = DW'(m12) + DW'(m21);
    case (br)
      BR_TRACE: begin
        d[0] = s1; d[1] = s2; d[2] = s3;
      end
      BR_X: begin
        d[0] = s1; d[1] = p1; d[2] = p2;
      end
      BR_Y: begin
        d[0] = s2; d[1] = p1; d[2] = p3;
      end
      default: begin
        d[0] = s3; d[1] = p2; d[2] = p3;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      neg[i] = d[i][DW-1];
      mag[i] = neg[i] ? MW'(-d[i]) : MW'(d[i]);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (!q_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      ctrl_r.branch <= br;
      ctrl_r.neg    <= neg;
      rad_r         <= rad_s[RDW-1:0];
      mag_r         <= mag;
    end
  end

  assign f_valid = valid_r;
  assign f_ctrl  = ctrl_r;
  assign f_rad   = rad_r;
  assign f_mag   = mag_r;

endmodule

`default_nettype wire

[hw/rtl/rmq_queue.sv]
// ----------------------------------------------------------------------------
// rmq_queue
// Short queue between the front and the back, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  output logic               full,
  output logic               rd_valid,
  output logic [DW-1:0]      rd_data
);
  import rmq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd_valid_r;
  logic [DW-1:0] rd_data_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      rd_valid_r <= do_pop;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (do_pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_data  = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/rmq_back.sv]
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, one root bit a stage, then three pipelined dividers,
// one quotient bit a stage, then saturation and placement of the components.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_back #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        b_valid,
  input  wire rmq_pkg::rmq_ctrl_t                          b_ctrl,
  input  wire logic [rmq_pkg::rad_w(DATA_WIDTH, FRAC_BITS)-1:0] b_rad,
  input  wire logic [2:0][rmq_pkg::mag_w(DATA_WIDTH)-1:0]       b_mag,
  output logic                                             o_valid,
  output logic [3:0][DATA_WIDTH-1:0]                       o_quat,
  output logic [1:0]                                       o_branch
);
  import rmq_pkg::*;

  localparam int RDW  = rad_w(DATA_WIDTH, FRAC_BITS);
  localparam int XE   = sqx_w(DATA_WIDTH, FRAC_BITS);
  localparam int RW   = root_w(DATA_WIDTH, FRAC_BITS);
  localparam int REMW = RW + 3;
  localparam int SW   = RW + 2;
  localparam int MJW  = RW + 1;
  localparam int MW   = mag_w(DATA_WIDTH);
  localparam int NW   = num_w(DATA_WIDTH, FRAC_BITS);
  localparam int DRW  = SW + 1;
  localparam int CW   = MJW + DATA_WIDTH;
  localparam logic [DATA_WIDTH-1:0] MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // square root stages
  logic               sq_v_r    [RW];
  rmq_ctrl_t          sq_ctrl_r [RW];
  logic [2:0][MW-1:0] sq_mag_r  [RW];
  logic [XE-1:0]      sq_x_r    [RW];
  logic [REMW-1:0]    sq_rem_r  [RW];
  logic [RW-1:0]      sq_root_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sq
    logic               v_in;
    rmq_ctrl_t          ctrl_in;
    logic [2:0][MW-1:0] mag_in;
    logic [XE-1:0]      x_in;
    logic [REMW-1:0]    rem_in, rem_sh, trial;
    logic [RW-1:0]      root_in;
    logic               ge;

    if (k == 0) begin : g_first
      assign v_in    = b_valid;
      assign ctrl_in = b_ctrl;
      assign mag_in  = b_mag;
      assign x_in    = XE'({b_rad, {FRAC_BITS{1'b0}}});
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sq_v_r[k-1];
      assign ctrl_in = sq_ctrl_r[k-1];
      assign mag_in  = sq_mag_r[k-1];
      assign x_in    = sq_x_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
    end

    assign rem_sh = {rem_in[REMW-3:0], x_in[XE-1 -: 2]};
    assign trial  = REMW'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else begin
        sq_v_r[k] <= v_in;
      end
      sq_ctrl_r[k] <= ctrl_in;
      sq_mag_r[k]  <= mag_in;
      sq_x_r[k]    <= x_in << 2;
      sq_rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
      sq_root_r[k] <= {root_in[RW-2:0], ge};
    end
  end

  // round to nearest
  logic               rd_v_r;
  rmq_ctrl_t          rd_ctrl_r;
  logic [2:0][MW-1:0] rd_mag_r;
  logic [MJW-1:0]     rd_root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= sq_v_r[RW-1];
    end
    rd_ctrl_r <= sq_ctrl_r[RW-1];
    rd_mag_r  <= sq_mag_r[RW-1];
    rd_root_r <= MJW'(sq_root_r[RW-1])
               + MJW'(sq_rem_r[RW-1] > REMW'(sq_root_r[RW-1]));
  end

  // divisor, major component and numerators
  logic                pp_v_r;
  rmq_ctrl_t           pp_ctrl_r;
  logic [SW-1:0]       pp_s_r;
  logic [MJW-1:0]      pp_major_r;
  logic [2:0][NW-1:0]  pp_num_r;
  logic [MJW:0]        root_inc;

  assign root_inc = {1'b0, rd_root_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_v_r <= 1'b0;
    end else begin
      pp_v_r <= rd_v_r;
    end
    pp_ctrl_r  <= rd_ctrl_r;
    pp_s_r     <= {rd_root_r, 1'b0};
    pp_major_r <= root_inc[MJW:1];
    for (int i = 0; i < 3; i++) begin
      pp_num_r[i] <= NW'({rd_mag_r[i], {FRAC_BITS{1'b0}}}) + NW'(rd_root_r);
    end
  end

  // division stages
  logic                dv_v_r     [NW];
  rmq_ctrl_t           dv_ctrl_r  [NW];
  logic [SW-1:0]       dv_s_r     [NW];
  logic [MJW-1:0]      dv_major_r [NW];
  logic [2:0][NW-1:0]  dv_num_r   [NW];
  logic [2:0][DRW-1:0] dv_rem_r   [NW];
  logic [2:0][NW-1:0]  dv_q_r     [NW];

  for (genvar j = 0; j < NW; j++) begin : g_dv
    logic                v_in;
    rmq_ctrl_t           ctrl_in;
    logic [SW-1:0]       s_in;
    logic [MJW-1:0]      major_in;
    logic [2:0][NW-1:0]  num_in, q_in, q_o, num_o;
    logic [2:0][DRW-1:0] rem_in, rem_o;

    if (j == 0) begin : g_first
      assign v_in     = pp_v_r;
      assign ctrl_in  = pp_ctrl_r;
      assign s_in     = pp_s_r;
      assign major_in = pp_major_r;
      assign num_in   = pp_num_r;
      assign rem_in   = '0;
      assign q_in     = '0;
    end else begin : g_next
      assign v_in     = dv_v_r[j-1];
      assign ctrl_in  = dv_ctrl_r[j-1];
      assign s_in     = dv_s_r[j-1];
      assign major_in = dv_major_r[j-1];
      assign num_in   = dv_num_r[j-1];
      assign rem_in   = dv_rem_r[j-1];
      assign q_in     = dv_q_r[j-1];
    end

    always_comb begin
      logic [DRW-1:0] sh;
      logic           ge;
      for (int i = 0; i < 3; i++) begin
        sh       = {rem_in[i][DRW-2:0], num_in[i][NW-1]};
        ge       = (sh >= DRW'(s_in));
        rem_o[i] = ge ? sh - DRW'(s_in) : sh;
        q_o[i]   = {q_in[i][NW-2:0], ge};
        num_o[i] = num_in[i] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else begin
        dv_v_r[j] <= v_in;
      end
      dv_ctrl_r[j]  <= ctrl_in;
      dv_s_r[j]     <= s_in;
      dv_major_r[j] <= major_in;
      dv_num_r[j]   <= num_o;
      dv_rem_r[j]   <= rem_o;
      dv_q_r[j]     <= q_o;
    end
  end

  // saturate and place
  rmq_ctrl_t                 fin_ctrl;
  logic [2:0][NW-1:0]        fin_q;
  logic [DATA_WIDTH-1:0]     lane [3];
  logic [DATA_WIDTH-1:0]     major_s;
  logic [3:0][DATA_WIDTH-1:0] quat;
  logic [1:0]                li;

  assign fin_ctrl = dv_ctrl_r[NW-1];
  assign fin_q    = dv_q_r[NW-1];

  always_comb begin
    major_s = (CW'(dv_major_r[NW-1]) > CW'(MAXP)) ? MAXP
                                                  : DATA_WIDTH'(dv_major_r[NW-1]);
    for (int i = 0; i < 3; i++) begin
      if (!fin_ctrl.neg[i]) begin
        lane[i] = (fin_q[i] > NW'(MAXP)) ? MAXP : fin_q[i][DATA_WIDTH-1:0];
      end else begin
        lane[i] = (fin_q[i] > NW'(MINN)) ? MINN
                                         : (~fin_q[i][DATA_WIDTH-1:0]) + 1'b1;
      end
    end
    for (int i = 0; i < 4; i++) begin
      li = (2'(i) < fin_ctrl.branch) ? 2'(i) : 2'(i - 1);
      if (2'(i) == fin_ctrl.branch) begin
        quat[i] = major_s;
      end else begin
        quat[i] = lane[li];
      end
    end
  end

  logic                       o_valid_r;
  logic [3:0][DATA_WIDTH-1:0] o_quat_r;
  logic [1:0]                 o_branch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= dv_v_r[NW-1];
    end
    o_quat_r   <= quat;
    o_branch_r <= fin_ctrl.branch;
  end

  assign o_valid  = o_valid_r;
  assign o_quat   = o_quat_r;
  assign o_branch = o_branch_r;

endmodule

`default_nettype wire

[hw/rtl/rmq_checker.sv]
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks on the matrix-to-quaternion block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_checker #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire logic [DATA_WIDTH-1:0] out_quat_w,
  input wire logic [DATA_WIDTH-1:0] out_quat_x,
  input wire logic [DATA_WIDTH-1:0] out_quat_y,
  input wire logic [DATA_WIDTH-1:0] out_quat_z,
  input wire logic [1:0]            out_branch_taken
);
  import rmq_pkg::*;

  localparam int LAT = latency(DATA_WIDTH, FRAC_BITS);

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised in operation");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result beat without a matching input beat");

  a_major_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_branch_taken == BR_TRACE && !out_quat_w[DATA_WIDTH-1]) ||
      (out_branch_taken == BR_X && !out_quat_x[DATA_WIDTH-1]) ||
      (out_branch_taken == BR_Y && !out_quat_y[DATA_WIDTH-1]) ||
      (out_branch_taken == BR_Z && !out_quat_z[DATA_WIDTH-1]))
    else $error("major component negative");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
  .DATA_WIDTH (DATA_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_rmq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_quat_w       (out_quat_w),
  .out_quat_x       (out_quat_x),
  .out_quat_y       (out_quat_y),
  .out_quat_z       (out_quat_z),
  .out_branch_taken (out_branch_taken)
);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the matrix-to-quaternion block: directed corner
// matrices, then random rotations, near-rotations and raw noise, with
// random start gaps; every result beat is checked against a local model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rmq_pkg::*;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam int LAT = 54;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    word_t       w;
    word_t       x;
    word_t       y;
    word_t       z;
    rmq_branch_t br;
  } quat_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  word_t m [9];
  logic out_valid;
  word_t out_w, out_x, out_y, out_z;
  logic [1:0] out_br;

  quat_t quat_q[$];
  int errors;

  rotation_matrix_to_quaternion uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_m_r0c0(m[0]), .in_m_r0c1(m[1]), .in_m_r0c2(m[2]),
    .in_m_r1c0(m[3]), .in_m_r1c1(m[4]), .in_m_r1c2(m[5]),
    .in_m_r2c0(m[6]), .in_m_r2c1(m[7]), .in_m_r2c2(m[8]),
    .out_valid(out_valid), .out_quat_w(out_w), .out_quat_x(out_x),
    .out_quat_y(out_y), .out_quat_z(out_z), .out_branch_taken(out_br)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic word_t clip(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return word_t'(v);
  endfunction

  function automatic longint div_round(longint d, longint s);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< FB) + (s >>> 1)) / s;
    return (d < 0) ? -q : q;
  endfunction

  function automatic quat_t shepperd(word_t a [9]);
    longint e [9];
    longint tr, r, xs, rt, s, mj;
    longint q0, q1, q2, q3;
    quat_t res;
    for (int i = 0; i < 9; i++) e[i] = a[i];
    tr = e[0] + e[4] + e[8];
    if (tr > 0) begin
      res.br = BR_TRACE;
      r = (1 <<< FB) + tr;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      res.br = BR_X;
      r = (1 <<< FB) + e[0] - e[4] - e[8];
    end else if (e[4] > e[8]) begin
      res.br = BR_Y;
      r = (1 <<< FB) + e[4] - e[0] - e[8];
    end else begin
      res.br = BR_Z;
      r = (1 <<< FB) + e[8] - e[0] - e[4];
    end
    if (r <= 0) r = 1;
    xs = r <<< FB;
    rt = longint'($floor($sqrt(real'(xs))));
    while (rt * rt > xs) rt--;
    while ((rt + 1) * (rt + 1) <= xs) rt++;
    if (xs - rt * rt > rt) rt++;
    s = 2 * rt;
    mj = (rt + 1) >>> 1;
    case (res.br)
      BR_TRACE: begin
        q0 = mj;
        q1 = div_round(e[7] - e[5], s);
        q2 = div_round(e[2] - e[6], s);
        q3 = div_round(e[3] - e[1], s);
      end
      BR_X: begin
        q0 = div_round(e[7] - e[5], s);
        q1 = mj;
        q2 = div_round(e[1] + e[3], s);
        q3 = div_round(e[2] + e[6], s);
      end
      BR_Y: begin
        q0 = div_round(e[2] - e[6], s);
        q1 = div_round(e[1] + e[3], s);
        q2 = mj;
        q3 = div_round(e[5] + e[7], s);
      end
      default: begin
        q0 = div_round(e[3] - e[1], s);
        q1 = div_round(e[2] + e[6], s);
        q2 = div_round(e[5] + e[7], s);
        q3 = mj;
      end
    endcase
    res.w = clip(q0);
    res.x = clip(q1);
    res.y = clip(q2);
    res.z = clip(q3);
    return res;
  endfunction

  always @(posedge clk) begin
    quat_t exp_q;
    if (rst_n && out_valid) begin
      if (quat_q.size() == 0) begin
        $display("%0t: unexpected beat w=%0d x=%0d y=%0d z=%0d br=%0d",
                 $time, out_w, out_x, out_y, out_z, out_br);
        errors++;
      end else begin
        exp_q = quat_q.pop_front();
        if (out_w !== exp_q.w || out_x !== exp_q.x || out_y !== exp_q.y ||
            out_z !== exp_q.z || out_br !== exp_q.br) begin
          $display("%0t: mismatch exp w=%0d x=%0d y=%0d z=%0d br=%0d", $time,
                   exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.br);
          $display("%0t:          act w=%0d x=%0d y=%0d z=%0d br=%0d", $time,
                   out_w, out_x, out_y, out_z, out_br);
          errors++;
        end
      end
    end
  end

  task automatic send_matrix(input word_t a [9]);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) m[i] <= a[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    quat_q.push_back(shepperd(a));
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return word_t'($urandom_range(0, 32768) - 16384);
      default: return word_t'($urandom());
    endcase
  endfunction

  // build a rotation from a random unit quaternion, with optional jitter
  function automatic void rand_rotation(output word_t a [9], input int jit);
    real qw, qx, qy, qz, n;
    real r [9];
    qw = $urandom_range(0, 2000) - 1000.0;
    qx = $urandom_range(0, 2000) - 1000.0;
    qy = $urandom_range(0, 2000) - 1000.0;
    qz = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz) + 1e-9;
    qw /= n; qx /= n; qy /= n; qz /= n;
    r[0] = 1 - 2 * (qy * qy + qz * qz);
    r[1] = 2 * (qx * qy - qz * qw);
    r[2] = 2 * (qx * qz + qy * qw);
    r[3] = 2 * (qx * qy + qz * qw);
    r[4] = 1 - 2 * (qx * qx + qz * qz);
    r[5] = 2 * (qy * qz - qx * qw);
    r[6] = 2 * (qx * qz - qy * qw);
    r[7] = 2 * (qy * qz + qx * qw);
    r[8] = 1 - 2 * (qx * qx + qy * qy);
    for (int i = 0; i < 9; i++)
      a[i] = clip(longint'(r[i] * 16384.0) + $urandom_range(0, 2 * jit) - jit);
  endfunction

  task automatic test_directed();
    word_t a [9];
    a = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(a);
    a = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(a);
    a = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(a);
    a = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(a);
    a = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; send_matrix(a);
    a = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(a);
    a = '{5, 0, 0, 0, 5, 0, 0, 0, 5}; send_matrix(a);
    a = '{-100, 0, 0, 0, -100, 0, 0, 0, -100}; send_matrix(a);
    a = '{-100, 7, 9, 3, -100, 1, 2, 8, -50}; send_matrix(a);
    for (int i = 0; i < 9; i++) a[i] = 16'sh7fff;
    send_matrix(a);
    for (int i = 0; i < 9; i++) a[i] = 16'sh8000;
    send_matrix(a);
    a = '{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768};
    send_matrix(a);
    a = '{-32768, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -32768};
    send_matrix(a);
    a = '{32767, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -32768};
    send_matrix(a);
    a = '{-32768, 32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768};
    send_matrix(a);
    a = '{-32768, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767};
    send_matrix(a);
    a = '{-16384, 32767, -32768, 32767, -16384, 32767, -32768, 32767, -16384};
    send_matrix(a);
    a = '{-20000, 0, 0, 0, -20000, 0, 0, 0, 100}; send_matrix(a);
  endtask

  task automatic test_random();
    word_t a [9];
    for (int n = 0; n < 1650; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: rand_rotation(a, 0);
        5, 6: rand_rotation(a, $urandom_range(1, 400));
        7: begin
          rand_rotation(a, 0);
          a[$urandom_range(0, 8)] = rand_word();
        end
        default: for (int i = 0; i < 9; i++) a[i] = rand_word();
      endcase
      send_matrix(a);
    end
  endtask

  initial begin
    errors = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    for (int i = 0; i < 9; i++) m[i] <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    start <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0 && quat_q.size() == 0)
      $display("rotation_matrix_to_quaternion verification clean");
    else
      $display("rotation_matrix_to_quaternion verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("rotation_matrix_to_quaternion verification failed");
    $finish;
  end

endmodule

`default_nettype wire
